// File: design/pcx_rle_decoder_assert.svh
// Assertion macros for the PCX run-length decoder.
`ifndef PCX_RLE_DECODER_ASSERT_SVH
`define PCX_RLE_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PCX_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCX_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCX_ASSERT(label, clk, rst_n, prop, msg)
`define PCX_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: design/pcx_pkg.sv
// Types, constants and helpers shared by the PCX run-length decoder.
`default_nettype none

package pcx_pkg;

  localparam int HeaderBytesDefault = 128;

  localparam logic [7:0] RunMark = 8'hC0;
  localparam logic [7:0] RunMask = 8'h3F;

  localparam logic [7:0] OFS_XMIN_LO = 8'd4;
  localparam logic [7:0] OFS_XMIN_HI = 8'd5;
  localparam logic [7:0] OFS_YMIN_LO = 8'd6;
  localparam logic [7:0] OFS_YMIN_HI = 8'd7;
  localparam logic [7:0] OFS_XMAX_LO = 8'd8;
  localparam logic [7:0] OFS_XMAX_HI = 8'd9;
  localparam logic [7:0] OFS_YMAX_LO = 8'd10;
  localparam logic [7:0] OFS_YMAX_HI = 8'd11;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  pixel;
    logic [15:0] row;
    logic [15:0] column;
    logic        last_of_run;
    logic        image_done;
  } pixel_t;

  typedef struct packed {
    logic take_header;
    logic set_run;
    logic clear_run;
    logic start_emit;
    logic use_pending;
    logic emit_pixel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic header_done;
    logic finished;
    logic awaiting;
    logic run_mark;
    logic run_zero;
    logic out_free;
    logic emit_last;
    logic emit_done;
  } dp_status_t;

  function automatic logic [16:0] span(input logic [15:0] lo, input logic [15:0] hi);
    logic [16:0] res;
    if (hi < lo) begin
      res = 17'd0;
    end else begin
      res = {1'b0, hi} - {1'b0, lo} + 17'd1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: design/pcx_stream_if.sv
// Valid/ready stream interface carrying one request payload.
`default_nettype none

interface pcx_stream_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/pcx_datapath.sv
// Datapath of the PCX decoder: header capture, run store, position counters, output register.
`default_nettype none

module pcx_datapath #(
  parameter int HEADER_BYTES = pcx_pkg::HeaderBytesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pcx_pkg::ctrl_cmd_t cmd_i,
  output pcx_pkg::dp_status_t     status_o,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output pcx_pkg::pixel_t         out_data_o
);
  import pcx_pkg::*;

  localparam logic [7:0] HdrCount = 8'(HEADER_BYTES);
  localparam logic [7:0] HdrLast  = 8'(HEADER_BYTES - 1);

  logic [7:0]  hdr_idx_q, hdr_idx_d;
  logic [15:0] xmin_q, xmin_d, ymin_q, ymin_d, xmax_q, xmax_d, ymax_q, ymax_d;
  logic [16:0] width_q, width_d, height_q, height_d;
  logic [5:0]  pend_q, pend_d, rem_q, rem_d;
  logic        await_q, await_d, fin_q, fin_d;
  logic [16:0] row_q, row_d;
  logic [15:0] col_q, col_d;
  logic [7:0]  val_q, val_d;
  logic        out_valid_q, out_valid_d;
  pixel_t      out_q, out_d;

  logic [16:0] col_nx, row_nx;
  logic        wrap, done, last;

  assign col_nx = {1'b0, col_q} + 17'd1;
  assign row_nx = row_q + 17'd1;
  assign wrap   = col_nx >= width_q;
  assign done   = wrap && (row_nx >= height_q);
  assign last   = (rem_q == 6'd1) || done;

  always_comb begin
    hdr_idx_d   = hdr_idx_q;
    xmin_d      = xmin_q;
    ymin_d      = ymin_q;
    xmax_d      = xmax_q;
    ymax_d      = ymax_q;
    width_d     = width_q;
    height_d    = height_q;
    pend_d      = pend_q;
    await_d     = await_q;
    fin_d       = fin_q;
    row_d       = row_q;
    col_d       = col_q;
    rem_d       = rem_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (cmd_i.take_header) begin
      hdr_idx_d = hdr_idx_q + 8'd1;
      case (hdr_idx_q)
        OFS_XMIN_LO: xmin_d = {8'h00, in_byte_i};
        OFS_XMIN_HI: xmin_d = {in_byte_i, xmin_q[7:0]};
        OFS_YMIN_LO: ymin_d = {8'h00, in_byte_i};
        OFS_YMIN_HI: ymin_d = {in_byte_i, ymin_q[7:0]};
        OFS_XMAX_LO: xmax_d = {8'h00, in_byte_i};
        OFS_XMAX_HI: xmax_d = {in_byte_i, xmax_q[7:0]};
        OFS_YMAX_LO: ymax_d = {8'h00, in_byte_i};
        OFS_YMAX_HI: ymax_d = {in_byte_i, ymax_q[7:0]};
        default: ;
      endcase
      if (hdr_idx_q == HdrLast) begin
        width_d  = span(xmin_d, xmax_d);
        height_d = span(ymin_d, ymax_d);
        if ((width_d == 17'd0) || (height_d == 17'd0)) begin
          fin_d = 1'b1;
        end
      end
    end

    if (cmd_i.set_run) begin
      pend_d  = in_byte_i[5:0] & RunMask[5:0];
      await_d = 1'b1;
    end
    if (cmd_i.clear_run) begin
      pend_d  = 6'd0;
      await_d = 1'b0;
    end

    if (cmd_i.start_emit) begin
      rem_d = cmd_i.use_pending ? pend_q : 6'd1;
      val_d = in_byte_i;
    end

    if (cmd_i.emit_pixel) begin
      out_valid_d       = 1'b1;
      out_d.pixel       = val_q;
      out_d.row         = row_q[15:0];
      out_d.column      = col_q;
      out_d.last_of_run = last;
      out_d.image_done  = done;
      rem_d             = rem_q - 6'd1;
      if (wrap) begin
        col_d = 16'd0;
        row_d = row_nx;
        if (done) begin
          fin_d = 1'b1;
        end
      end else begin
        col_d = col_nx[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q   <= 8'd0;
      xmin_q      <= 16'd0;
      ymin_q      <= 16'd0;
      xmax_q      <= 16'd0;
      ymax_q      <= 16'd0;
      width_q     <= 17'd0;
      height_q    <= 17'd0;
      pend_q      <= 6'd0;
      await_q     <= 1'b0;
      fin_q       <= 1'b0;
      row_q       <= 17'd0;
      col_q       <= 16'd0;
      rem_q       <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      hdr_idx_q   <= hdr_idx_d;
      xmin_q      <= xmin_d;
      ymin_q      <= ymin_d;
      xmax_q      <= xmax_d;
      ymax_q      <= ymax_d;
      width_q     <= width_d;
      height_q    <= height_d;
      pend_q      <= pend_d;
      await_q     <= await_d;
      fin_q       <= fin_d;
      row_q       <= row_d;
      col_q       <= col_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    out_q <= out_d;
  end

  assign status_o.header_done = hdr_idx_q == HdrCount;
  assign status_o.finished    = fin_q;
  assign status_o.awaiting    = await_q;
  assign status_o.run_mark    = in_byte_i >= RunMark;
  assign status_o.run_zero    = pend_q == 6'd0;
  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign status_o.emit_last   = last;
  assign status_o.emit_done   = done;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: design/pcx_ctrl.sv
// Controller of the PCX decoder: byte classification and run emission sequencing.
`default_nettype none

module pcx_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pcx_pkg::dp_status_t status_i,
  output pcx_pkg::ctrl_cmd_t       cmd_o
);
  import pcx_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;
  logic take;

  assign in_ready_o = state_q == ST_IDLE;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (!status_i.header_done) begin
            cmd_o.take_header = 1'b1;
          end else if (!status_i.finished) begin
            if (status_i.awaiting) begin
              cmd_o.clear_run = 1'b1;
              if (!status_i.run_zero) begin
                cmd_o.start_emit  = 1'b1;
                cmd_o.use_pending = 1'b1;
                state_d           = ST_EMIT;
              end
            end else if (status_i.run_mark) begin
              cmd_o.set_run = 1'b1;
            end else begin
              cmd_o.start_emit = 1'b1;
              state_d          = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_pixel = 1'b1;
          if (status_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: design/pcx_rle_decoder.sv
// PCX run-length decoder: one file byte per request in, one pixel per request out.
// The first HEADER_BYTES requests are header bytes, and the image
// bounds are read from offsets 4 to 11 (little-endian xmin, ymin, xmax, ymax). After
// the header a run marker byte (0xC0 and above) is accepted without output; a literal
// byte is accepted, then emitted, and a run value byte is accepted, then emitted as a
// run of N pixels; the emit sequencer loads one pixel per cycle into the single
// output register while that register is free, so back-pressure on the output stalls emission;
// a new byte is taken while the last pixel still waits in that register. Each pixel
// carries its row and column, last_of_run on the final pixel of its byte, and
// image_done on the pixel that completes the last row; later bytes are dropped.
`default_nettype none
`include "pcx_rle_decoder_assert.svh"

module pcx_rle_decoder #(
  parameter int HEADER_BYTES = pcx_pkg::HeaderBytesDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  pcx_stream_if.sink    in_i,
  pcx_stream_if.source  out_o
);
  import pcx_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_i.ready = in_ready;

  pcx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pcx_datapath #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_byte_i   (in_i.data.in_byte),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

  `PCX_ASSERT(a_done_sets_finished, clk_i, rst_ni, cmd.emit_pixel && status.emit_done |=> status.finished, "image end did not stop decoding")
  `PCX_ASSERT(a_no_pixel_in_header, clk_i, rst_ni, out_o.valid |-> status.header_done, "pixel before header end")
  `PCX_ASSERT(a_done_is_last, clk_i, rst_ni, out_o.valid && out_o.data.image_done |-> out_o.data.last_of_run, "image end pixel not last of run")
  `PCX_ASSERT(a_no_emit_after_finish, clk_i, rst_ni, status.finished |-> !cmd.start_emit, "emission started after image end")
  `PCX_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_o.valid, "output valid during reset")

endmodule

`default_nettype wire
